// File: hdl/dedup_handle_table_defines.svh
// Assertion helpers shared by the handle table RTL.
`ifndef DEDUP_HANDLE_TABLE_DEFINES_SVH
`define DEDUP_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DHT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/dht_pkg.sv
package dht_pkg;

   localparam int CAPACITY = 64;
   localparam logic [31:0] HANDLE_MAX = 32'hFFFF_FFFF;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] thread_in;
      logic [31:0] level_in;
      logic [31:0] handle_in;
   } req_type;

   typedef struct packed {
      logic [31:0] handle_out;
      logic        is_new;
      logic        found;
      logic [31:0] thread_out;
      logic [31:0] level_out;
      logic        table_full;
   } rsp_type;

   // Query walking down the cell row, plus the first hit picked up so far.
   typedef struct packed {
      logic             valid;
      logic             is_lookup;
      logic             lookup_ok;
      logic [IDX_W-1:0] idx;
      logic [31:0]      thread;
      logic [31:0]      level;
      logic [31:0]      handle;
      logic             hit;
      logic [31:0]      hit_handle;
      logic [31:0]      hit_thread;
      logic [31:0]      hit_level;
   } probe_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] slot;
      logic [31:0]      handle;
      logic [31:0]      thread;
      logic [31:0]      level;
   } write_type;

endpackage

// File: hdl/dedup_handle_table.sv
// Interning table for (thread, level) entries. Each entry lives in one cell of
// a row of CAPACITY cells; an insert or lookup is sent down the row as a probe
// that moves one cell per clock and picks up the first matching entry. An
// insert or lookup therefore produces its result once the probe has passed
// the whole cell row, while clear and the unused mode skip the row. One
// request is in flight at a time, and the next request beat is taken while
// the previous result still waits on rsp_ready.
`include "dedup_handle_table_defines.svh"

module dedup_handle_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dht_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type state_ff;
   dht_pkg::req_type req_ff;
   dht_pkg::probe_type res_ff;
   logic [31:0] base_ff;
   logic [31:0] base_in;
   logic [dht_pkg::CNT_W-1:0] count_ff;
   logic [dht_pkg::CNT_W-1:0] count_in;
   logic rsp_valid_ff;
   dht_pkg::rsp_type rsp_ff;
   dht_pkg::rsp_type rsp_in;

   dht_pkg::probe_type head;
   dht_pkg::probe_type tail;
   dht_pkg::write_type wr;

   logic req_fire;
   logic fin_go;
   logic [31:0] count_w;
   logic [31:0] diff;
   logic [31:0] sum;
   logic [31:0] new_handle;
   logic [dht_pkg::CNT_W-1:0] cap_cnt;
   logic is_full;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;
   assign fin_go    = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign count_w   = 32'(count_ff);
   assign diff      = req_data.handle_in - base_ff;
   assign sum       = base_ff + count_w;
   assign new_handle = (base_ff > (dht_pkg::HANDLE_MAX - count_w)) ?
                       (sum - dht_pkg::HANDLE_MAX) : sum;
   assign cap_cnt   = dht_pkg::CNT_W'(dht_pkg::CAPACITY);
   assign is_full   = (count_ff == cap_cnt);

   always_comb begin
      head = '0;
      head.valid     = req_fire && ((req_data.mode == dht_pkg::MODE_INSERT)
                                    || (req_data.mode == dht_pkg::MODE_LOOKUP));
      head.is_lookup = (req_data.mode == dht_pkg::MODE_LOOKUP);
      head.lookup_ok = !(base_ff > req_data.handle_in) && (diff < count_w);
      head.idx       = diff[dht_pkg::IDX_W-1:0];
      head.thread    = req_data.thread_in;
      head.level     = req_data.level_in;
      head.handle    = req_data.handle_in;
   end

   dht_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .entry_count (count_ff),
      .wr          (wr),
      .head        (head),
      .tail        (tail)
   );

   always_comb begin
      wr        = '0;
      rsp_in    = '0;
      base_in   = base_ff;
      count_in  = count_ff;
      wr.slot   = count_ff[dht_pkg::IDX_W-1:0];
      wr.handle = new_handle;
      wr.thread = req_ff.thread_in;
      wr.level  = req_ff.level_in;
      unique case (req_ff.mode)
         dht_pkg::MODE_INSERT: begin
            if (res_ff.hit) begin
               rsp_in.handle_out = res_ff.hit_handle;
            end else if (is_full) begin
               rsp_in.table_full = 1'b1;
            end else begin
               wr.en             = fin_go;
               rsp_in.handle_out = new_handle;
               rsp_in.is_new     = 1'b1;
               count_in          = count_ff + 1'b1;
            end
         end
         dht_pkg::MODE_LOOKUP: begin
            if (res_ff.hit) begin
               rsp_in.handle_out = req_ff.handle_in;
               rsp_in.found      = 1'b1;
               rsp_in.thread_out = res_ff.hit_thread;
               rsp_in.level_out  = res_ff.hit_level;
            end
         end
         dht_pkg::MODE_CLEAR: begin
            base_in  = sum;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  req_ff <= req_data;
                  res_ff <= '0;
                  state_ff <= head.valid ? ST_SCAN : ST_FIN;
               end
            end
            ST_SCAN: begin
               if (tail.valid) begin
                  res_ff   <= tail;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (fin_go) begin
                  rsp_ff       <= rsp_in;
                  base_ff      <= base_in;
                  count_ff     <= count_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DHT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= cap_cnt, "count above capacity")
   `DHT_ASSERT_SAME(a_tail_in_scan, clock, reset, tail.valid, state_ff == ST_SCAN, "stray probe")
   `DHT_ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE, "stayed idle")
   `DHT_ASSERT_SAME(a_write_when_free, clock, reset, wr.en, !is_full && !res_ff.hit, "bad append")

endmodule

// File: hdl/dht_cell.sv
module dht_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dht_pkg::IDX_W-1:0]   cell_idx,
   input  logic [dht_pkg::CNT_W-1:0]   entry_count,
   input  dht_pkg::write_type          wr,
   input  dht_pkg::probe_type          probe_in,
   output dht_pkg::probe_type          probe_out
);

   logic [31:0] handle_ff;
   logic [31:0] thread_ff;
   logic [31:0] level_ff;
   dht_pkg::probe_type probe_ff;
   dht_pkg::probe_type probe_in_next;
   logic occupied;
   logic ins_match;
   logic lk_match;

   assign occupied = {{(dht_pkg::CNT_W - dht_pkg::IDX_W){1'b0}}, cell_idx} < entry_count;

   assign ins_match = !probe_in.is_lookup && occupied
                      && (thread_ff == probe_in.thread) && (level_ff == probe_in.level);
   // idx below count was checked at injection, so occupancy is implied
   assign lk_match = probe_in.is_lookup && probe_in.lookup_ok
                     && (probe_in.idx == cell_idx) && (handle_ff == probe_in.handle);

   always_comb begin
      probe_in_next = probe_in;
      if (!probe_in.hit && (ins_match || lk_match)) begin
         probe_in_next.hit        = 1'b1;
         probe_in_next.hit_handle = handle_ff;
         probe_in_next.hit_thread = thread_ff;
         probe_in_next.hit_level  = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.slot == cell_idx)) begin
         handle_ff <= wr.handle;
         thread_ff <= wr.thread;
         level_ff  <= wr.level;
      end
   end

   assign probe_out = probe_ff;

endmodule

// File: hdl/dht_chain.sv
module dht_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [dht_pkg::CNT_W-1:0] entry_count,
   input  dht_pkg::write_type        wr,
   input  dht_pkg::probe_type        head,
   output dht_pkg::probe_type        tail
);

   dht_pkg::probe_type link [0:dht_pkg::CAPACITY];

   assign link[0] = head;

   for (genvar i = 0; i < dht_pkg::CAPACITY; i++) begin : g_cell
      dht_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (dht_pkg::IDX_W'(i)),
         .entry_count (entry_count),
         .wr          (wr),
         .probe_in    (link[i]),
         .probe_out   (link[i+1])
      );
   end

   assign tail = link[dht_pkg::CAPACITY];

endmodule
